### hdl/tbdc_pkg.sv
// ----------------------------------------------------------------------------
// tbdc_pkg
// shared types and constants for the two-beam direction counter
// ----------------------------------------------------------------------------
package tbdc_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int TIMER_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int OCC_WIDTH   = 16;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_WINDOW_TICKS  = 1'b0,
		REG_LOCKOUT_TICKS = 1'b1
	} tbdc_reg_t;

	localparam logic [CFG_WIDTH-1:0] WINDOW_RESET  = 16'd5000;
	localparam logic [CFG_WIDTH-1:0] LOCKOUT_RESET = 16'd320;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_ENTRY   = 2'd1,
		EV_EXIT    = 2'd2,
		EV_TIMEOUT = 2'd3
	} tbdc_event_t;

	typedef struct packed {
		logic outer_beam;
		logic inner_beam;
	} tbdc_in_t;

	typedef struct packed {
		logic signed [OCC_WIDTH-1:0] occupancy;
		logic                        occupied;
		tbdc_event_t                 event_code;
	} tbdc_out_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] window_ticks;
		logic [CFG_WIDTH-1:0] lockout_ticks;
	} tbdc_cfg_t;

endpackage

### hdl/tbdc_core.sv
// ----------------------------------------------------------------------------
// tbdc_core
// phase, window/lockout timer and saturating people count, one step per word
// ----------------------------------------------------------------------------
module tbdc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tbdc_pkg::tbdc_cfg_t cfg,
	input  tbdc_pkg::tbdc_in_t  sample,
	output tbdc_pkg::tbdc_out_t result
);
	import tbdc_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE       = 4'b0001,
		PH_WAIT_INNER = 4'b0010,
		PH_WAIT_OUTER = 4'b0100,
		PH_LOCKOUT    = 4'b1000
	} tbdc_phase_t;

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	tbdc_phase_t                    phase_q, phase_d;
	logic [TIMER_WIDTH-1:0]         timer_q, timer_d;
	logic signed [COUNT_WIDTH-1:0]  count_q, count_d;
	tbdc_event_t                    ev;

	logic                   outer_blk, inner_blk, first_blk, second_blk;
	logic [TIMER_WIDTH-1:0] window_lim, lockout_lim;
	logic [31:0]            window_ext, lockout_ext;

	assign outer_blk = !sample.outer_beam;
	assign inner_blk = !sample.inner_beam;

	// window and lockout clamp to what the timer can hold
	assign window_ext  = 32'(cfg.window_ticks);
	assign lockout_ext = 32'(cfg.lockout_ticks);
	assign window_lim  = (window_ext > 32'(TIMER_MAX)) ? TIMER_MAX : TIMER_WIDTH'(window_ext);
	assign lockout_lim = (lockout_ext > 32'(TIMER_MAX)) ? TIMER_MAX : TIMER_WIDTH'(lockout_ext);

	// the beam that opened the wait restarts it; the other one completes it
	assign first_blk  = (phase_q == PH_WAIT_INNER) ? outer_blk : inner_blk;
	assign second_blk = (phase_q == PH_WAIT_INNER) ? inner_blk : outer_blk;

	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		count_d = count_q;
		ev      = EV_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (outer_blk) begin
					phase_d = PH_WAIT_INNER;
					timer_d = '0;
				end else if (inner_blk) begin
					phase_d = PH_WAIT_OUTER;
					timer_d = '0;
				end
			end
			PH_WAIT_INNER, PH_WAIT_OUTER: begin
				if (first_blk) begin
					timer_d = '0;
				end else if (second_blk) begin
					if (phase_q == PH_WAIT_INNER) begin
						ev = EV_ENTRY;
						if (count_q != CNT_MAX) count_d = count_q + 1'b1;
					end else begin
						ev = EV_EXIT;
						if (count_q != CNT_MIN) count_d = count_q - 1'b1;
					end
					if (lockout_lim == '0) begin
						phase_d = PH_IDLE;
						timer_d = '0;
					end else begin
						phase_d = PH_LOCKOUT;
						timer_d = lockout_lim;
					end
				end else if (timer_q >= window_lim) begin
					ev      = EV_TIMEOUT;
					phase_d = PH_IDLE;
					timer_d = '0;
				end else begin
					timer_d = timer_q + 1'b1;
				end
			end
			PH_LOCKOUT: begin
				if (timer_q > 1) begin
					timer_d = timer_q - 1'b1;
				end else begin
					timer_d = '0;
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			count_q <= count_d;
		end
	end

	assign result.occupancy  = OCC_WIDTH'(count_d);
	assign result.occupied   = !count_d[COUNT_WIDTH-1] && (count_d != '0);
	assign result.event_code = ev;

endmodule

### hdl/two_beam_direction_counter_top.sv
// ----------------------------------------------------------------------------
// two_beam_direction_counter_top
// doorway people counter from two active-low beam sensors
// ----------------------------------------------------------------------------
// usage:
//   in channel  (in_valid/in_ready/in_word): one sensor sample per timer tick,
//   outer_beam and inner_beam, 0 meaning the beam is blocked.
//   out channel (out_valid/out_ready/out_word): exactly one word per sample
//   with the updated occupancy, the occupied flag and an event code.
//   cfg port (cfg_we/cfg_index/cfg_data): window_ticks at index 0,
//   lockout_ticks at index 1, written while no sample is in flight.
// output: each result word is registered and shown the cycle after its sample.
// throughput: one sample per cycle unless the receiver stalls; the whole state
//   update is a single pass of logic in front of the output register.
// stall: in_ready stays high while the output register is empty or is being
//   emptied this cycle; a stalled receiver holds out_word and backs up input.
// reset: occupancy zero, idle phase, window 5000 and lockout 320 ticks,
//   output register empty.
// ----------------------------------------------------------------------------
module two_beam_direction_counter_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tbdc_pkg::tbdc_in_t    in_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tbdc_pkg::tbdc_out_t   out_word,
	input  logic                  cfg_we,
	input  tbdc_pkg::tbdc_reg_t   cfg_index,
	input  logic [tbdc_pkg::CFG_WIDTH-1:0] cfg_data
);
	import tbdc_pkg::*;

	tbdc_cfg_t cfg_q;
	tbdc_out_t result;
	tbdc_out_t out_word_s1;
	logic      out_valid_s1;
	logic      accept;

	assign in_ready = !out_valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ticks  <= WINDOW_RESET;
			cfg_q.lockout_ticks <= LOCKOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_TICKS:  cfg_q.window_ticks  <= cfg_data;
				REG_LOCKOUT_TICKS: cfg_q.lockout_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	tbdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cfg    (cfg_q),
		.sample (in_word),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			out_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_s1 <= result;
		end
	end

	assign out_valid = out_valid_s1;
	assign out_word  = out_word_s1;

endmodule

### hdl/tbdc_checker.sv
// ----------------------------------------------------------------------------
// tbdc_checker
// port-level checks for the two-beam direction counter
// ----------------------------------------------------------------------------
module tbdc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input tbdc_pkg::tbdc_out_t out_word
);
	import tbdc_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// every accepted sample yields a result word on the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result word after accepted sample");

	// an empty output register never blocks input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// occupied flag agrees with a positive count
	a_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.occupied ==
			(!out_word.occupancy[OCC_WIDTH-1] && (out_word.occupancy != '0))))
		else $error("occupied flag disagrees with occupancy");

endmodule

bind two_beam_direction_counter_top tbdc_checker u_tbdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
